/* rtl/stk_pkg.sv */
`default_nettype none

package stk_pkg;

   // table size and name length
   localparam int DEFAULT_CAPACITY = 128;
   localparam int NAME_BYTES       = 11;

   // masks that zero the name bytes beyond the name length
   localparam logic [63:0] NAME_LOW_MASK =
      (NAME_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * NAME_BYTES)) - 64'd1);
   localparam logic [23:0] NAME_HIGH_MASK =
      (NAME_BYTES <= 8)  ? 24'd0 :
      (NAME_BYTES >= 11) ? {24{1'b1}} :
      ((24'd1 << (8 * (NAME_BYTES - 8))) - 24'd1);

   // action and status codes
   localparam logic ACT_INSERT   = 1'b0;
   localparam logic ACT_READ     = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // request transaction
   typedef struct packed {
      logic               action;
      logic [63:0]        name_low;
      logic [23:0]        name_high;
      logic signed [31:0] score;
      logic [6:0]         rank;
   } req_type;

   // response transaction
   typedef struct packed {
      logic               status;
      logic [7:0]         count;
      logic               kept;
      logic [63:0]        out_name_low;
      logic [23:0]        out_name_high;
      logic signed [31:0] out_score;
   } rsp_type;

   // one stored table entry
   typedef struct packed {
      logic [63:0]        name_low;
      logic [23:0]        name_high;
      logic signed [31:0] score;
   } entry_type;

   // controller state
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_READ,
      ST_RDOUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_en;
      logic scan;
      logic ld_ins;
      logic ld_rd;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic rank_ok;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/stk_datapath.sv */
`default_nettype none

module stk_datapath #(
   parameter int  CAPACITY = stk_pkg::DEFAULT_CAPACITY,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire stk_pkg::cmd_type cmd,
   input  wire logic [CW-1:0]    idx,
   input  wire stk_pkg::req_type req_data,
   input  wire logic             rsp_stall,
   output stk_pkg::sts_type      sts,
   output logic [CW-1:0]         count,
   output logic                  rsp_valid,
   output stk_pkg::rsp_type      rsp_data
);
   import stk_pkg::*;

   localparam int RW = CW + 7;

   entry_type       mem [CAPACITY];
   entry_type       new_ff;
   entry_type       held_ff;
   entry_type       rdata_ff;
   entry_type       entry_in;
   logic            ins_ff;
   logic [6:0]      rank_ff;
   logic            proc_ff;
   logic [AW-1:0]   widx_ff;
   logic [AW-1:0]   raddr;
   logic [AW-1:0]   waddr;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            pass;
   logic            not_full;
   logic            we;
   logic            rank_ok;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;
   logic            rsp_valid_ff;

   // masked copy of the incoming entry
   always_comb begin
      entry_in.name_low  = req_data.name_low & NAME_LOW_MASK;
      entry_in.name_high = req_data.name_high & NAME_HIGH_MASK;
      entry_in.score     = req_data.score;
   end

   // walk decisions
   assign not_full = (count_ff < CW'(CAPACITY));
   assign pass     = ins_ff || ($signed(rdata_ff.score) <= $signed(new_ff.score));
   assign rank_ok  = (RW'(rank_ff) < RW'(count_ff));

   // memory addressing: walk entries or the requested rank
   assign raddr = cmd.scan ? idx[AW-1:0] : AW'(rank_ff);
   assign we    = (proc_ff && pass) || (cmd.ld_ins && not_full);
   assign waddr = proc_ff ? widx_ff : AW'(count_ff);

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= held_ff;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   // request capture and carried entry
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         new_ff  <= entry_in;
         held_ff <= entry_in;
         rank_ff <= req_data.rank;
      end else if (proc_ff && pass) begin
         held_ff <= rdata_ff;
      end
      widx_ff <= raddr;
   end

   // walk control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff  <= 1'b0;
         proc_ff <= 1'b0;
      end else begin
         proc_ff <= cmd.rd_en && cmd.scan;
         if (cmd.accept) begin
            ins_ff <= 1'b0;
         end else if (proc_ff && pass) begin
            ins_ff <= 1'b1;
         end
      end
   end

   // entry count
   assign count_in = (cmd.ld_ins && not_full) ? count_ff + CW'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response build
   always_comb begin
      rsp_in = '0;
      if (cmd.ld_ins) begin
         rsp_in.status = STATUS_OK;
         rsp_in.count  = 8'(count_in);
         rsp_in.kept   = not_full || ins_ff;
      end else begin
         rsp_in.count = 8'(count_ff);
         if (rank_ok) begin
            rsp_in.status        = STATUS_OK;
            rsp_in.out_name_low  = rdata_ff.name_low;
            rsp_in.out_name_high = rdata_ff.name_high;
            rsp_in.out_score     = rdata_ff.score;
         end else begin
            rsp_in.status = STATUS_RANGE;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.ld_ins || cmd.ld_rd) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_ins || cmd.ld_rd) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign count        = count_ff;
   assign sts.rank_ok  = rank_ok;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // count stays within the table
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   // writes land only on stored entries or the first free slot
   a_write_addr : assert property (@(posedge clock) disable iff (reset)
      we |-> (CW'(waddr) <= count_ff))
      else $error("table write beyond entry count");

   // tail write never overlaps the walk
   a_tail_after_walk : assert property (@(posedge clock) disable iff (reset)
      cmd.ld_ins |-> !proc_ff)
      else $error("insert finished while walk still active");

endmodule

`default_nettype wire

/* rtl/stk_ctrl.sv */
`default_nettype none

module stk_ctrl #(
   parameter int  CAPACITY = stk_pkg::DEFAULT_CAPACITY,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_action,
   input  wire stk_pkg::sts_type sts,
   input  wire logic [CW-1:0]    count,
   output stk_pkg::cmd_type      cmd,
   output logic [CW-1:0]         idx,
   output logic                  req_stall
);
   import stk_pkg::*;

   state_type     state_ff;
   state_type     state_in;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] idx_in;
   logic          issue;

   assign issue = (idx_ff < count);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_action == ACT_READ) ? ST_READ : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!issue) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_RDOUT;
         end
         ST_RDOUT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands and walk counter
   always_comb begin
      cmd    = '0;
      idx_in = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            idx_in     = '0;
         end
         ST_SCAN: begin
            cmd.scan  = 1'b1;
            cmd.rd_en = issue;
            if (issue) begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_FINISH: begin
            cmd.ld_ins = sts.out_free;
         end
         ST_READ: begin
            cmd.rd_en = sts.rank_ok;
         end
         ST_RDOUT: begin
            cmd.ld_rd = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign idx       = idx_ff;
   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/sorted_top_k_insert_table.sv */
// Sorted top-k table of named scores, highest score at rank 0.
// Request channel (req_valid, req_stall, req_data): action insert places the
// entry before the first stored entry with a score less than or equal to its
// own, so a newer entry goes ahead of equal scores; a full table drops its last
// entry, possibly the new one (kept 0). Action read returns the entry at rank,
// or status 1 with zeroed entry fields when rank is at or beyond the count.
// Response channel (rsp_valid, rsp_stall, rsp_data): one transaction per
// request, carrying the entry count after the request.
// An insert walks the stored entries one per cycle through the table memory's
// single read and write port, from rank 0 to the last entry before the insert.
// A read fetches the entry at rank before its response is loaded. One request
// is worked on at a time; the next is accepted in the cycle after the response
// is loaded into the output register.
// A stalled response holds in the output register; a finished request waits
// until the register is free. Reset empties the table (count 0) and
// clears the response valid; entry storage itself is not cleared.
`default_nettype none

module sorted_top_k_insert_table #(
   parameter int CAPACITY = stk_pkg::DEFAULT_CAPACITY
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire stk_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output stk_pkg::rsp_type      rsp_data
);
   import stk_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   cmd_type       cmd;
   sts_type       sts;
   logic [CW-1:0] idx;
   logic [CW-1:0] count;

   // sequencer
   stk_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .sts        (sts),
      .count      (count),
      .cmd        (cmd),
      .idx        (idx),
      .req_stall  (req_stall)
   );

   // table memory, walk and output register
   stk_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .idx       (idx),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .count     (count),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
